@@ design/ehcvd_pkg.sv @@
// ----------------------------------------------------------------------------
// ehcvd_pkg: shared types and constants of the clause varint decoder
// Byte layout constants, the accumulator state and the per-byte step result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ehcvd_pkg;

    // Byte layout: bits 6..0 carry data, bit 7 marks continuation
    localparam int unsigned DATA_W   = 7;
    localparam int unsigned CONT_BIT = 7;

    // At most five bytes of one varint carry data; the fifth keeps four bits
    localparam logic [2:0] MAX_BYTES = 3'd5;
    localparam logic [2:0] LAST_POS  = 3'd4;

    // Record byte count saturates here
    localparam logic [7:0] BYTES_SAT = 8'd255;

    // Fields carried by one result
    localparam int unsigned OUT_FIELDS = 6;

    // Varint being decoded
    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  pos;
    } ehcvd_acc_t;

    // Outcome of folding one byte into the accumulator
    typedef struct packed {
        ehcvd_acc_t acc;
        logic       over_hit;
        logic       done;
    } ehcvd_step_t;

endpackage : ehcvd_pkg

`default_nettype wire

@@ design/ehcvd_if.sv @@
// ----------------------------------------------------------------------------
// ehcvd_if: valid/ready channels of the clause varint decoder
// Byte request channel and clause result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ehcvd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface : ehcvd_byte_if

interface ehcvd_clause_if;
    logic        valid;
    logic        ready;
    logic [31:0] clause_flags;
    logic [31:0] try_offset;
    logic [31:0] try_length;
    logic [31:0] handler_offset;
    logic [31:0] handler_length;
    logic [31:0] filter_offset;
    logic [7:0]  bytes_used;
    logic        overlong;

    modport source (
        output valid, input ready,
        output clause_flags, output try_offset, output try_length,
        output handler_offset, output handler_length, output filter_offset,
        output bytes_used, output overlong
    );
    modport sink (
        input valid, output ready,
        input clause_flags, input try_offset, input try_length,
        input handler_offset, input handler_length, input filter_offset,
        input bytes_used, input overlong
    );
endinterface : ehcvd_clause_if

`default_nettype wire

@@ design/ehcvd_step.sv @@
// ----------------------------------------------------------------------------
// ehcvd_step: fold one LEB128 byte into the varint accumulator
// Places the seven data bits at 7*pos, flags data past bit 31 or a sixth byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ehcvd_step
    import ehcvd_pkg::*;
(
    input  wire logic [7:0] byte_in,
    input  wire ehcvd_acc_t acc,
    output ehcvd_step_t     step
);

    logic [DATA_W-1:0] data;
    logic [31:0]       shifted;

    assign data = byte_in[DATA_W-1:0];

    // Position the data bits for the current byte slot
    always_comb
    begin
        unique case (acc.pos)
            3'd0:    shifted = {25'b0, data};
            3'd1:    shifted = {18'b0, data, 7'b0};
            3'd2:    shifted = {11'b0, data, 14'b0};
            3'd3:    shifted = {4'b0, data, 21'b0};
            3'd4:    shifted = {data[3:0], 28'b0};
            default: shifted = '0;
        endcase
    end

    // Accumulate, advance the position, flag overlong input
    always_comb
    begin
        step.acc      = acc;
        step.over_hit = 1'b0;
        step.done     = ~byte_in[CONT_BIT];
        if (acc.pos < MAX_BYTES)
        begin
            step.acc.value = acc.value | shifted;
            step.acc.pos   = acc.pos + 3'd1;
            if (acc.pos == LAST_POS && data[6:4] != 3'b0)
            begin
                step.over_hit = 1'b1;
            end
        end
        else
        begin
            step.over_hit = 1'b1;
        end
    end

endmodule : ehcvd_step

`default_nettype wire

@@ design/eh_clause_varint_decoder.sv @@
// ----------------------------------------------------------------------------
// eh_clause_varint_decoder: exception clause LEB128 decoder
// Decodes NUM_FIELDS unsigned varints per clause and emits one clause record.
// ----------------------------------------------------------------------------
// Usage:
//   bytes   : one encoded byte per request (valid/ready); bit 7 = continuation.
//   clauses : one record per clause once the last varint of the clause ends:
//             six fields, bytes_used (saturating at 255) and overlong.
//   Throughput is one byte per cycle while bytes.ready stays high. Each
//   accepted byte lands in an input register and is folded into the
//   accumulator from there, and the final byte of a clause loads its record.
//   The record sits in an output register; bytes keep flowing while it
//   waits. Only a final byte that would close a new clause while the
//   previous record is still unread holds the input register, and then
//   bytes.ready drops until clauses.ready frees the output register.
//   Reset (rst_n low) empties both registers and restarts at the first
//   varint of a fresh clause; no clearing pass is needed.
//   Data above bit 31 or beyond a fifth byte of one varint is dropped and
//   sets overlong for that clause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eh_clause_varint_decoder
    import ehcvd_pkg::*;
#(
    parameter int unsigned NUM_FIELDS = 6
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    ehcvd_byte_if.sink       bytes,
    ehcvd_clause_if.source   clauses
);

    localparam int unsigned FIDX_W = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;
    localparam int unsigned DONE_N = (NUM_FIELDS > 1) ? NUM_FIELDS - 1 : 1;
    localparam logic [FIDX_W-1:0] LAST_FIELD = FIDX_W'(NUM_FIELDS - 1);

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Decode state
    ehcvd_acc_t        acc_reg;
    logic [FIDX_W-1:0] field_index_reg;
    logic [31:0]       done_reg [DONE_N];
    logic [7:0]        record_bytes_reg;
    logic              overlong_reg;

    // Output register
    logic        out_valid_reg;
    logic [31:0] out_field_reg [OUT_FIELDS];
    logic [7:0]  out_bytes_reg;
    logic        out_over_reg;

    ehcvd_step_t step;
    logic        last_field;
    logic        clause_end;
    logic        out_free;
    logic        advance;
    logic [7:0]  record_bytes_next;
    logic        overlong_next;
    logic [31:0] field_next [OUT_FIELDS];

    ehcvd_step u_step (
        .byte_in (in_byte_reg),
        .acc     (acc_reg),
        .step    (step)
    );

    // Handshake control
    assign last_field = (field_index_reg == LAST_FIELD);
    assign clause_end = in_valid_reg && step.done && last_field;
    assign out_free   = !out_valid_reg || clauses.ready;
    assign advance    = in_valid_reg && (!clause_end || out_free);
    assign bytes.ready = !in_valid_reg || advance;

    assign record_bytes_next = (record_bytes_reg < BYTES_SAT) ?
                               record_bytes_reg + 8'd1 : record_bytes_reg;
    assign overlong_next     = overlong_reg | step.over_hit;

    // Map stored fields and the closing varint onto the record
    for (genvar k = 0; k < OUT_FIELDS; k++)
    begin : g_field
        if (k < NUM_FIELDS - 1)
        begin : g_done
            assign field_next[k] = done_reg[k];
        end
        else if (k == NUM_FIELDS - 1)
        begin : g_cur
            assign field_next[k] = step.acc.value;
        end
        else
        begin : g_zero
            assign field_next[k] = '0;
        end
    end

    // Capture an incoming byte request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (bytes.ready)
        begin
            in_valid_reg <= bytes.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.ready && bytes.valid)
        begin
            in_byte_reg <= bytes.byte_in;
        end
    end

    // Advance the decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg          <= '0;
            field_index_reg  <= '0;
            record_bytes_reg <= '0;
            overlong_reg     <= 1'b0;
        end
        else if (advance)
        begin
            if (clause_end)
            begin
                acc_reg          <= '0;
                field_index_reg  <= '0;
                record_bytes_reg <= '0;
                overlong_reg     <= 1'b0;
            end
            else if (step.done)
            begin
                acc_reg          <= '0;
                field_index_reg  <= field_index_reg + FIDX_W'(1);
                record_bytes_reg <= record_bytes_next;
                overlong_reg     <= overlong_next;
            end
            else
            begin
                acc_reg          <= step.acc;
                record_bytes_reg <= record_bytes_next;
                overlong_reg     <= overlong_next;
            end
        end
    end

    // Store each completed varint of the clause
    for (genvar i = 0; i < DONE_N; i++)
    begin : g_done_store
        always_ff @(posedge clk)
        begin
            if (advance && step.done && !last_field &&
                field_index_reg == FIDX_W'(i))
            begin
                done_reg[i] <= step.acc.value;
            end
        end
    end

    // Hold the record until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && clause_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (clauses.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && clause_end)
        begin
            out_field_reg <= field_next;
            out_bytes_reg <= record_bytes_next;
            out_over_reg  <= overlong_next;
        end
    end

    assign clauses.valid          = out_valid_reg;
    assign clauses.clause_flags   = out_field_reg[0];
    assign clauses.try_offset     = out_field_reg[1];
    assign clauses.try_length     = out_field_reg[2];
    assign clauses.handler_offset = out_field_reg[3];
    assign clauses.handler_length = out_field_reg[4];
    assign clauses.filter_offset  = out_field_reg[5];
    assign clauses.bytes_used     = out_bytes_reg;
    assign clauses.overlong       = out_over_reg;

`ifndef SYNTHESIS
    // A record is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && clause_end) |-> out_free)
        else $error("record loaded over an unread record");

    // Closing a clause restarts the decode state
    a_clause_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && clause_end) |=>
            (field_index_reg == '0 && record_bytes_reg == '0 &&
             !overlong_reg && acc_reg.pos == '0))
        else $error("decode state not cleared after clause");

    // Byte position never passes the five-byte limit
    a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg.pos <= MAX_BYTES)
        else $error("byte position out of range");

    // Field index stays within the clause
    a_field_limit: assert property (@(posedge clk) disable iff (!rst_n)
        field_index_reg <= LAST_FIELD)
        else $error("field index out of range");
`endif

endmodule : eh_clause_varint_decoder

`default_nettype wire
